>>> design/ellipse_in_rect_rasterizer_defines.svh
// assertion macros for the ellipse rasterizer checker
// no dependencies; taken in by the checker file
`ifndef ELLIPSE_IN_RECT_RASTERIZER_DEFINES_SVH
`define ELLIPSE_IN_RECT_RASTERIZER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define EIR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ellipse rasterizer check failed");

// next-cycle implication, sampled on the rising clock edge
`define EIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ellipse rasterizer check failed");

`endif

>>> design/eir_pkg.sv
// shared types and codes for the ellipse rasterizer
// used by the controller, the datapath, the top level and the checker
package eir_pkg;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_SCALE,
      ST_LOAD_ACC,
      ST_STEP_UPD,
      ST_STEP_OUT
   } eir_state_type;

   typedef struct packed {
      logic capture;   // take corners, sort, derive width and height
      logic mul;       // square width and height
      logic scale;     // form error increments and step sizes
      logic init_acc;  // form the error accumulator, start the ellipse
      logic step_upd;  // snapshot pixel, move coordinates and increments
      logic emit;      // fold increments into accumulator, load result
   } eir_cmd_type;

   typedef struct packed {
      logic busy;
      logic out_free;
   } eir_status_type;

endpackage

>>> design/eir_ctrl.sv
// controller state machine of the ellipse rasterizer
// depends on eir_pkg; drives commands into eir_datapath
module eir_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   input  eir_pkg::eir_status_type status,
   output eir_pkg::eir_cmd_type    cmd
);

   eir_pkg::eir_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eir_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         eir_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == eir_pkg::MODE_LOAD) begin
                  cmd.capture = 1'b1;
                  state_in    = eir_pkg::ST_LOAD_MUL;
               end else if (status.busy) begin
                  state_in = eir_pkg::ST_STEP_UPD;
               end
            end
         end
         eir_pkg::ST_LOAD_MUL: begin
            cmd.mul  = 1'b1;
            state_in = eir_pkg::ST_LOAD_SCALE;
         end
         eir_pkg::ST_LOAD_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = eir_pkg::ST_LOAD_ACC;
         end
         eir_pkg::ST_LOAD_ACC: begin
            cmd.init_acc = 1'b1;
            state_in     = eir_pkg::ST_IDLE;
         end
         eir_pkg::ST_STEP_UPD: begin
            cmd.step_upd = 1'b1;
            state_in     = eir_pkg::ST_STEP_OUT;
         end
         eir_pkg::ST_STEP_OUT: begin
            // hold here until the result register can take the pixel set
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = eir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eir_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/eir_datapath.sv
// datapath of the ellipse rasterizer: setup multiplies, error terms,
// coordinates and the result register; depends on eir_pkg
module eir_datapath #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  eir_pkg::eir_cmd_type          cmd,
   output eir_pkg::eir_status_type       status,
   input  logic [COORD_BITS-1:0]         req_corner_a_x,
   input  logic [COORD_BITS-1:0]         req_corner_a_y,
   input  logic [COORD_BITS-1:0]         req_corner_b_x,
   input  logic [COORD_BITS-1:0]         req_corner_b_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_left_x,
   output logic signed [COORD_BITS+1:0]  rsp_right_x,
   output logic signed [COORD_BITS+1:0]  rsp_lower_row_y,
   output logic signed [COORD_BITS+1:0]  rsp_upper_row_y,
   output logic                          rsp_in_tip,
   output logic                          rsp_final_step
);

   localparam int CB = COORD_BITS;
   localparam int OB = CB + 2;       // coordinate width
   localparam int MB = 2 * CB;       // square width
   localparam int PB = 3 * CB + 2;   // (1 - w) * h * h
   localparam int SB = 2 * CB + 3;   // 8 * square
   localparam int EB = 4 * CB + 4;   // error term width

   // control state
   logic busy_ff, busy_in;
   logic tip_ff, tip_in;
   logic rsp_valid_ff, rsp_valid_in;

   // ellipse state
   logic signed [OB-1:0] cur_left_ff, cur_left_in;
   logic signed [OB-1:0] cur_right_ff, cur_right_in;
   logic signed [OB-1:0] cur_row_down_ff, cur_row_down_in;
   logic signed [OB-1:0] cur_row_up_ff, cur_row_up_in;
   logic [CB-1:0]        w_ff, w_in;
   logic [CB-1:0]        h_ff, h_in;
   logic [MB-1:0]        hh_ff, hh_in;
   logic [MB-1:0]        ww_ff, ww_in;
   logic signed [EB-1:0] x_err_ff, x_err_in;
   logic signed [EB-1:0] y_err_ff, y_err_in;
   logic signed [EB-1:0] acc_ff, acc_in;
   logic [SB-1:0]        x_step_ff, x_step_in;
   logic [SB-1:0]        y_step_ff, y_step_in;
   logic                 cx_ff, cx_in;
   logic                 cy_ff, cy_in;

   // pixel snapshot taken before the step moves the coordinates
   logic signed [OB-1:0] pix_left_ff, pix_left_in;
   logic signed [OB-1:0] pix_right_ff, pix_right_in;
   logic signed [OB-1:0] pix_down_ff, pix_down_in;
   logic signed [OB-1:0] pix_up_ff, pix_up_in;
   logic                 pix_tip_ff, pix_tip_in;

   // result register
   logic signed [OB-1:0] out_left_ff, out_left_in;
   logic signed [OB-1:0] out_right_ff, out_right_in;
   logic signed [OB-1:0] out_down_ff, out_down_in;
   logic signed [OB-1:0] out_up_ff, out_up_in;
   logic                 out_tip_ff, out_tip_in;
   logic                 out_final_ff, out_final_in;

   // corner sorting
   logic                 ax_lt_bx, ay_lt_by;
   logic [CB-1:0]        lo_x, lo_y, w_cap, h_cap, half_h;
   logic signed [OB-1:0] cap_down;

   // setup arithmetic
   logic signed [CB:0]   one_minus_w;
   logic signed [PB-1:0] prod;
   logic signed [EB-1:0] odd_ww;

   // step arithmetic
   logic signed [EB:0]   e2, x_err_ext, y_err_ext;
   logic                 step_cx, step_cy;
   logic signed [OB:0]   span, h_ext;
   logic                 span_short, cols_open;

   assign ax_lt_bx = req_corner_a_x < req_corner_b_x;
   assign ay_lt_by = req_corner_a_y < req_corner_b_y;
   assign lo_x     = ax_lt_bx ? req_corner_a_x : req_corner_b_x;
   assign lo_y     = ay_lt_by ? req_corner_a_y : req_corner_b_y;
   assign w_cap    = ax_lt_bx ? req_corner_b_x - req_corner_a_x
                              : req_corner_a_x - req_corner_b_x;
   assign h_cap    = ay_lt_by ? req_corner_b_y - req_corner_a_y
                              : req_corner_a_y - req_corner_b_y;
   assign half_h   = CB'(({1'b0, h_cap} + (CB+1)'(1)) >> 1);
   assign cap_down = OB'(lo_y) + OB'(half_h);

   assign one_minus_w = (CB+1)'(1) - (CB+1)'(w_ff);
   assign prod        = one_minus_w * $signed({1'b0, hh_ff});
   assign odd_ww      = h_ff[0] ? EB'(ww_ff) : '0;

   assign e2        = {acc_ff, 1'b0};
   assign x_err_ext = (EB+1)'(x_err_ff);
   assign y_err_ext = (EB+1)'(y_err_ff);
   assign step_cx   = e2 >= x_err_ext;
   assign step_cy   = e2 <= y_err_ext;

   assign span       = (OB+1)'(cur_row_down_ff) - (OB+1)'(cur_row_up_ff);
   assign h_ext      = (OB+1)'(h_ff);
   assign span_short = span < h_ext;
   assign cols_open  = cur_left_ff <= cur_right_ff;

   always_comb begin
      busy_in         = busy_ff;
      tip_in          = tip_ff;
      cur_left_in     = cur_left_ff;
      cur_right_in    = cur_right_ff;
      cur_row_down_in = cur_row_down_ff;
      cur_row_up_in   = cur_row_up_ff;
      w_in            = w_ff;
      h_in            = h_ff;
      hh_in           = hh_ff;
      ww_in           = ww_ff;
      x_err_in        = x_err_ff;
      y_err_in        = y_err_ff;
      acc_in          = acc_ff;
      x_step_in       = x_step_ff;
      y_step_in       = y_step_ff;
      cx_in           = cx_ff;
      cy_in           = cy_ff;
      pix_left_in     = pix_left_ff;
      pix_right_in    = pix_right_ff;
      pix_down_in     = pix_down_ff;
      pix_up_in       = pix_up_ff;
      pix_tip_in      = pix_tip_ff;
      out_left_in     = out_left_ff;
      out_right_in    = out_right_ff;
      out_down_in     = out_down_ff;
      out_up_in       = out_up_ff;
      out_tip_in      = out_tip_ff;
      out_final_in    = out_final_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (cmd.capture) begin
         cur_left_in     = OB'(lo_x);
         cur_right_in    = OB'(lo_x) + OB'(w_cap);
         cur_row_down_in = cap_down;
         cur_row_up_in   = cap_down - OB'(h_cap[0]);
         w_in            = w_cap;
         h_in            = h_cap;
      end

      if (cmd.mul) begin
         hh_in = MB'(h_ff) * MB'(h_ff);
         ww_in = MB'(w_ff) * MB'(w_ff);
      end

      if (cmd.scale) begin
         x_err_in  = (EB'(prod)) <<< 2;
         y_err_in  = h_ff[0] ? EB'({ww_ff, 3'b000}) : EB'({ww_ff, 2'b00});
         x_step_in = {hh_ff, 3'b000};
         y_step_in = {ww_ff, 3'b000};
      end

      if (cmd.init_acc) begin
         acc_in  = x_err_ff + y_err_ff + odd_ww;
         busy_in = 1'b1;
         tip_in  = 1'b0;
      end

      if (cmd.step_upd) begin
         pix_down_in = cur_row_down_ff;
         pix_up_in   = cur_row_up_ff;
         pix_tip_in  = tip_ff;
         if (tip_ff) begin
            // tip phase: columns sit one beyond the final ones, rows spread
            pix_left_in     = cur_left_ff - OB'(1);
            pix_right_in    = cur_right_ff + OB'(1);
            cur_row_down_in = cur_row_down_ff + OB'(1);
            cur_row_up_in   = cur_row_up_ff - OB'(1);
            cx_in           = 1'b0;
            cy_in           = 1'b0;
         end else begin
            pix_left_in  = cur_left_ff;
            pix_right_in = cur_right_ff;
            cx_in        = step_cx;
            cy_in        = step_cy;
            if (step_cx) begin
               cur_left_in  = cur_left_ff + OB'(1);
               cur_right_in = cur_right_ff - OB'(1);
               x_err_in     = x_err_ff + EB'(x_step_ff);
            end
            if (step_cy) begin
               cur_row_down_in = cur_row_down_ff + OB'(1);
               cur_row_up_in   = cur_row_up_ff - OB'(1);
               y_err_in        = y_err_ff + EB'(y_step_ff);
            end
         end
      end

      if (cmd.emit) begin
         // increments already hold their post-step values here
         acc_in       = acc_ff + (cx_ff ? x_err_ff : '0) + (cy_ff ? y_err_ff : '0);
         out_left_in  = pix_left_ff;
         out_right_in = pix_right_ff;
         out_down_in  = pix_down_ff;
         out_up_in    = pix_up_ff;
         out_tip_in   = pix_tip_ff;
         rsp_valid_in = 1'b1;
         out_final_in = 1'b0;
         if (tip_ff) begin
            if (!span_short) begin
               busy_in      = 1'b0;
               tip_in       = 1'b0;
               out_final_in = 1'b1;
            end
         end else if (!cols_open) begin
            if (span_short) begin
               tip_in = 1'b1;
            end else begin
               busy_in      = 1'b0;
               out_final_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         tip_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         tip_ff       <= tip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff     <= cur_left_in;
      cur_right_ff    <= cur_right_in;
      cur_row_down_ff <= cur_row_down_in;
      cur_row_up_ff   <= cur_row_up_in;
      w_ff            <= w_in;
      h_ff            <= h_in;
      hh_ff           <= hh_in;
      ww_ff           <= ww_in;
      x_err_ff        <= x_err_in;
      y_err_ff        <= y_err_in;
      acc_ff          <= acc_in;
      x_step_ff       <= x_step_in;
      y_step_ff       <= y_step_in;
      cx_ff           <= cx_in;
      cy_ff           <= cy_in;
      pix_left_ff     <= pix_left_in;
      pix_right_ff    <= pix_right_in;
      pix_down_ff     <= pix_down_in;
      pix_up_ff       <= pix_up_in;
      pix_tip_ff      <= pix_tip_in;
      out_left_ff     <= out_left_in;
      out_right_ff    <= out_right_in;
      out_down_ff     <= out_down_in;
      out_up_ff       <= out_up_in;
      out_tip_ff      <= out_tip_in;
      out_final_ff    <= out_final_in;
   end

   assign status.busy     = busy_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_x      = out_left_ff;
   assign rsp_right_x     = out_right_ff;
   assign rsp_lower_row_y = out_down_ff;
   assign rsp_upper_row_y = out_up_ff;
   assign rsp_in_tip      = out_tip_ff;
   assign rsp_final_step  = out_final_ff;

endmodule

>>> design/ellipse_in_rect_rasterizer.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   mode, two rectangle corners
// rsp       out        rsp_valid/rsp_stall   two columns, two rows, tip, last
//
// a load runs through accept, square, scale, accumulator setup
// a step with an ellipse in progress runs through accept, update, result load;
// the result load waits while the result register is full and stalled
// a step with no ellipse in progress is accepted and gives nothing
// reset is synchronous and leaves the block idle with no ellipse in progress
//
// top level of the ellipse rasterizer; depends on eir_pkg, eir_ctrl, eir_datapath
module ellipse_in_rect_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [COORD_BITS-1:0]         req_corner_a_x,
   input  logic [COORD_BITS-1:0]         req_corner_a_y,
   input  logic [COORD_BITS-1:0]         req_corner_b_x,
   input  logic [COORD_BITS-1:0]         req_corner_b_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS+1:0]  rsp_left_x,
   output logic signed [COORD_BITS+1:0]  rsp_right_x,
   output logic signed [COORD_BITS+1:0]  rsp_lower_row_y,
   output logic signed [COORD_BITS+1:0]  rsp_upper_row_y,
   output logic                          rsp_in_tip,
   output logic                          rsp_final_step
);

   eir_pkg::eir_cmd_type    cmd;
   eir_pkg::eir_status_type status;

   eir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   eir_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_corner_a_x  (req_corner_a_x),
      .req_corner_a_y  (req_corner_a_y),
      .req_corner_b_x  (req_corner_b_x),
      .req_corner_b_y  (req_corner_b_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_x      (rsp_left_x),
      .rsp_right_x     (rsp_right_x),
      .rsp_lower_row_y (rsp_lower_row_y),
      .rsp_upper_row_y (rsp_upper_row_y),
      .rsp_in_tip      (rsp_in_tip),
      .rsp_final_step  (rsp_final_step)
   );

endmodule

>>> design/eir_checker.sv
// port-level checks for the ellipse rasterizer, bound to the top level
// depends on eir_pkg and ellipse_in_rect_rasterizer_defines.svh
`include "ellipse_in_rect_rasterizer_defines.svh"

module eir_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_mode,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS+1:0]  rsp_left_x,
   input logic signed [COORD_BITS+1:0]  rsp_right_x,
   input logic signed [COORD_BITS+1:0]  rsp_lower_row_y,
   input logic signed [COORD_BITS+1:0]  rsp_upper_row_y,
   input logic                          rsp_in_tip,
   input logic                          rsp_final_step
);

   logic                      load_xfer;
   logic                      rsp_main;
   logic                      rsp_wait;
   logic [4*COORD_BITS+9:0]   rsp_payload;

   assign load_xfer   = req_valid && !req_stall && (req_mode == eir_pkg::MODE_LOAD);
   assign rsp_main    = rsp_valid && !rsp_in_tip;
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_left_x, rsp_right_x, rsp_lower_row_y, rsp_upper_row_y,
                         rsp_in_tip, rsp_final_step};

   // a load keeps the block busy with its setup for the following cycle
   `EIR_ASSERT_NEXT(a_load_busy, clock, reset, load_xfer, req_stall)

   // outside the tip phase the columns have not yet crossed
   `EIR_ASSERT_IMPL(a_cols_ordered, clock, reset, rsp_main, rsp_left_x <= rsp_right_x)

   // the lower row never sits above the upper row
   `EIR_ASSERT_IMPL(a_rows_ordered, clock, reset, rsp_valid, rsp_lower_row_y >= rsp_upper_row_y)

   // a stalled result holds
   `EIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_payload))

endmodule

bind ellipse_in_rect_rasterizer eir_checker #(.COORD_BITS(COORD_BITS)) u_eir_checker (.*);
